// File: rtl/smx_pkg.sv
// Shared types and constants for the stack machine execute unit.
package smx_pkg;

  localparam int unsigned STACK_DEPTH = 1024;
  localparam int unsigned PTR_W       = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned FUNC_W      = 4;
  localparam int unsigned DEPTH_W     = 11;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH = 4'd0,
    FN_POP  = 4'd1,
    FN_ADD  = 4'd2,
    FN_SUB  = 4'd3,
    FN_MUL  = 4'd4,
    FN_DIV  = 4'd5,
    FN_MOD  = 4'd6,
    FN_CMP  = 4'd7,
    FN_PEEK = 4'd8
  } func_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_PUSH,
    OP_POP,
    OP_PEEK,
    OP_CMP,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_MOD
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FEW  = 2'd1,
    ST_FULL = 2'd2,
    ST_DIV0 = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_EXEC,
    BK_DIV
  } back_state_e;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] operand;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [1:0]               status;
    logic                     compare_flag;
    logic [DEPTH_W-1:0]       depth;
  } out_t;

  typedef struct packed {
    op_e               op;
    logic [DATA_W-1:0] operand;
  } instr_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
  } div_rsp_t;

endpackage

// File: rtl/stack_machine_execute.sv
// Top level of the stack machine execute unit.
// Executes one instruction item (push, pop, add, sub, mul, div, mod, compare, peek) against
// a 1024-entry stack of 32-bit signed words and returns one result item per instruction.
// A two-item queue separates the decoding front end from the executing back end, so the
// front end accepts items until the queue is full while a result waits to be taken;
// the back end starts an instruction only when its output register is empty or being taken
// in that cycle. Push, peek, compare, unknown codes and every refused or erroring case end
// in the idle state; a pop that leaves entries adds a refill of the cached top from the RAM
// (BK_LOAD), add, sub and mul a read of the second entry through the registered RAM port
// (BK_EXEC), div and mod an operand read, a divider start and 32 one-bit divider steps
// (BK_EXEC, BK_DIV). The stack RAM needs no clearing pass.
module stack_machine_execute import smx_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic   q_valid;
  logic   q_pop;
  instr_t q_data;

  smx_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_data_o   (q_data),
    .q_pop_i    (q_pop)
  );

  smx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/smx_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module smx_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/smx_front.sv
// Front end: accepts instruction items, decodes them and queues them for the back end.
module smx_front import smx_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  in_t    in_data_i,
  output logic   q_valid_o,
  output instr_t q_data_o,
  input  logic   q_pop_i
);

  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  instr_t             slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               push, pop;
  instr_t             dec;

  always_comb begin
    dec.operand = in_data_i.operand;
    unique case (func_e'(in_data_i.func))
      FN_PUSH: dec.op = OP_PUSH;
      FN_POP:  dec.op = OP_POP;
      FN_ADD:  dec.op = OP_ADD;
      FN_SUB:  dec.op = OP_SUB;
      FN_MUL:  dec.op = OP_MUL;
      FN_DIV:  dec.op = OP_DIV;
      FN_MOD:  dec.op = OP_MOD;
      FN_CMP:  dec.op = OP_CMP;
      FN_PEEK: dec.op = OP_PEEK;
      default: dec.op = OP_NOP;
    endcase
  end

  assign in_stall_o = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign q_valid_o  = (cnt_q != '0);
  assign q_data_o   = slot_q[rd_ptr_q];
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= dec;
    end
  end

endmodule

// File: rtl/smx_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module smx_div import smx_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned STEP_W = $clog2(DATA_W);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [DATA_W-1:0] rem_q, quo_q, dvs_q;
  logic              qneg_q, rneg_q;
  logic [DATA_W:0]   trial, diff;
  logic [DATA_W-1:0] mag_dividend, mag_divisor;

  assign mag_dividend = req_i.dividend[DATA_W-1] ? -req_i.dividend : req_i.dividend;
  assign mag_divisor  = req_i.divisor[DATA_W-1]  ? -req_i.divisor  : req_i.divisor;

  assign trial = {rem_q, quo_q[DATA_W-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == STEP_W'(DATA_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= '0;
      quo_q  <= mag_dividend;
      dvs_q  <= mag_divisor;
      qneg_q <= req_i.dividend[DATA_W-1] ^ req_i.divisor[DATA_W-1];
      rneg_q <= req_i.dividend[DATA_W-1];
    end else if (busy_q) begin
      if (!diff[DATA_W]) begin
        rem_q <= diff[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = qneg_q ? -quo_q : quo_q;
  assign rsp_o.remainder = rneg_q ? -rem_q : rem_q;

endmodule

// File: rtl/smx_back.sv
// Back end: executes queued instructions against the operand stack and registers results.
module smx_back import smx_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   q_valid_i,
  input  instr_t q_data_i,
  output logic   q_pop_o,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output out_t   out_data_o
);

  back_state_e       state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              flag_q, flag_d;
  logic [DATA_W-1:0] top_q, top_d;
  op_e               op_q, op_d;
  logic              out_valid_q;
  out_t              out_q;

  logic              out_free, emit;
  logic [DATA_W-1:0] res_value;
  status_e           res_status;
  logic [CNT_W-1:0]  count_m1, count_m2;
  logic              wr_en, rd_en;
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] alu_res, mul_lo;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // top of stack lives in top_q; the store holds entries below it
  smx_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_m1[PTR_W-1:0]),
    .wr_data_i (top_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (count_m2[PTR_W-1:0]),
    .rd_data_o (rd_data)
  );

  smx_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign count_m1 = count_q - CNT_W'(1);
  assign count_m2 = count_q - CNT_W'(2);
  assign out_free = !out_valid_q || !out_stall_i;
  assign mul_lo   = rd_data * top_q;

  always_comb begin
    case (op_q)
      OP_ADD:  alu_res = rd_data + top_q;
      OP_SUB:  alu_res = rd_data - top_q;
      default: alu_res = mul_lo;
    endcase
  end

  always_comb begin
    state_d          = state_q;
    count_d          = count_q;
    flag_d           = flag_q;
    top_d            = top_q;
    op_d             = op_q;
    q_pop_o          = 1'b0;
    emit             = 1'b0;
    res_value        = '0;
    res_status       = ST_OK;
    wr_en            = 1'b0;
    rd_en            = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = rd_data;
    div_req.divisor  = top_q;

    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          unique case (q_data_i.op)
            OP_PUSH: begin
              emit      = 1'b1;
              res_value = q_data_i.operand;
              if (count_q == CNT_W'(STACK_DEPTH)) begin
                res_status = ST_FULL;
              end else begin
                wr_en   = (count_q != '0);
                top_d   = q_data_i.operand;
                count_d = count_q + CNT_W'(1);
              end
            end
            OP_POP, OP_PEEK, OP_CMP: begin
              emit = 1'b1;
              if (count_q == '0) begin
                res_value  = '1;
                res_status = ST_FEW;
              end else begin
                res_value = top_q;
                if (q_data_i.op == OP_CMP) begin
                  flag_d = (top_q == q_data_i.operand);
                end
                if (q_data_i.op == OP_POP) begin
                  count_d = count_m1;
                  if (count_q >= CNT_W'(2)) begin
                    rd_en   = 1'b1;
                    state_d = BK_LOAD;
                  end
                end
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
              if (count_q < CNT_W'(2)) begin
                emit       = 1'b1;
                res_status = ST_FEW;
              end else if ((q_data_i.op == OP_DIV || q_data_i.op == OP_MOD)
                           && top_q == '0) begin
                emit       = 1'b1;
                res_status = ST_DIV0;
              end else begin
                rd_en   = 1'b1;
                op_d    = q_data_i.op;
                state_d = BK_EXEC;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      BK_LOAD: begin
        top_d   = rd_data;
        state_d = BK_IDLE;
      end
      BK_EXEC: begin
        if (op_q == OP_DIV || op_q == OP_MOD) begin
          div_req.start = 1'b1;
          state_d       = BK_DIV;
        end else if (out_free) begin
          emit      = 1'b1;
          res_value = alu_res;
          top_d     = alu_res;
          count_d   = count_m1;
          state_d   = BK_IDLE;
        end
      end
      BK_DIV: begin
        if (div_rsp.done && out_free) begin
          emit      = 1'b1;
          res_value = (op_q == OP_MOD) ? div_rsp.remainder : div_rsp.quotient;
          top_d     = res_value;
          count_d   = count_m1;
          state_d   = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      count_q     <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      flag_q  <= flag_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    op_q  <= op_d;
    if (emit) begin
      out_q.value        <= res_value;
      out_q.status       <= res_status;
      out_q.compare_flag <= flag_d;
      out_q.depth        <= DEPTH_W'(count_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: test/stack_machine_execute_tb.sv
// Self-checking testbench for the stack machine execute unit: directed table, then random.
module stack_machine_execute_tb import smx_pkg::*; ();

  localparam int unsigned RANDOM_ITEMS = 100;
  localparam int unsigned N_DIRECTED   = 28;
  localparam logic [DATA_W-1:0] MIN_W   = 32'h8000_0000;
  localparam logic [DATA_W-1:0] MAX_W   = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] NEG_ONE = 32'hFFFF_FFFF;
  localparam logic [FUNC_W-1:0] FN_SPARE = 4'hF;

  typedef struct packed {
    in_t  stim;
    logic known;
    out_t result;
  } step_t;

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
  int unsigned       shadow_count = 0;
  logic              shadow_eq    = 1'b0;
  out_t              pending_results [$];
  out_t              want_result;
  int unsigned       errors    = 0;
  int unsigned       stall_left = 0;
  bit                no_idle   = 1'b0;

  func_e arith_ops [5] = '{FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_MOD};

  // known results are typed in; the rest come from the predictor
  step_t directed_steps [N_DIRECTED] = '{
    '{'{FN_PEEK, 32'd0},  1'b1, '{NEG_ONE, ST_FEW,  1'b0, 11'd0}},
    '{'{FN_POP,  32'd0},  1'b1, '{NEG_ONE, ST_FEW,  1'b0, 11'd0}},
    '{'{FN_CMP,  32'd0},  1'b1, '{NEG_ONE, ST_FEW,  1'b0, 11'd0}},
    '{'{FN_ADD,  32'd0},  1'b1, '{32'd0,   ST_FEW,  1'b0, 11'd0}},
    '{'{FN_PUSH, MAX_W},  1'b1, '{MAX_W,   ST_OK,   1'b0, 11'd1}},
    '{'{FN_MOD,  32'd0},  1'b1, '{32'd0,   ST_FEW,  1'b0, 11'd1}},
    '{'{FN_PUSH, MIN_W},  1'b1, '{MIN_W,   ST_OK,   1'b0, 11'd2}},
    '{'{FN_CMP,  MIN_W},  1'b1, '{MIN_W,   ST_OK,   1'b1, 11'd2}},
    '{'{FN_ADD,  32'd0},  1'b0, '0},
    '{'{FN_PUSH, 32'd0},  1'b0, '0},
    '{'{FN_DIV,  32'd0},  1'b1, '{32'd0,   ST_DIV0, 1'b1, 11'd2}},
    '{'{FN_MOD,  32'd0},  1'b1, '{32'd0,   ST_DIV0, 1'b1, 11'd2}},
    '{'{FN_POP,  32'd0},  1'b0, '0},
    '{'{FN_PUSH, MIN_W},  1'b0, '0},
    '{'{FN_PUSH, NEG_ONE}, 1'b0, '0},
    '{'{FN_DIV,  32'd0},  1'b1, '{MIN_W,   ST_OK,   1'b1, 11'd2}},
    '{'{FN_PUSH, NEG_ONE}, 1'b0, '0},
    '{'{FN_MOD,  32'd0},  1'b1, '{32'd0,   ST_OK,   1'b1, 11'd2}},
    '{'{FN_PUSH, 32'd7},  1'b0, '0},
    '{'{FN_SUB,  32'd0},  1'b0, '0},
    '{'{FN_MUL,  32'd0},  1'b0, '0},
    '{'{FN_PUSH, 32'hFFFF_FFFE}, 1'b0, '0},
    '{'{FN_DIV,  32'd0},  1'b0, '0},
    '{'{FN_PUSH, 32'd2},  1'b0, '0},
    '{'{FN_MOD,  32'd0},  1'b0, '0},
    '{'{FN_CMP,  32'd5},  1'b0, '0},
    '{'{FN_PEEK, 32'd0},  1'b0, '0},
    '{'{FN_SPARE, MAX_W}, 1'b0, '0}
  };

  stack_machine_execute dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic out_t execute_instr(input in_t x);
    out_t              r;
    logic [DATA_W-1:0] a, b, res;
    longint            sa, sb;
    r = '0;
    r.status = ST_OK;
    case (x.func)
      FN_PUSH: begin
        r.value = x.operand;
        if (shadow_count >= STACK_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_stack[shadow_count] = x.operand;
          shadow_count++;
        end
      end
      FN_POP, FN_PEEK, FN_CMP: begin
        if (shadow_count == 0) begin
          r.value  = NEG_ONE;
          r.status = ST_FEW;
        end else begin
          r.value = shadow_stack[shadow_count-1];
          if (x.func == FN_POP) shadow_count--;
          if (x.func == FN_CMP) shadow_eq = (r.value == x.operand);
        end
      end
      FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_MOD: begin
        if (shadow_count < 2) begin
          r.status = ST_FEW;
        end else begin
          a = shadow_stack[shadow_count-1];
          b = shadow_stack[shadow_count-2];
          if ((x.func == FN_DIV || x.func == FN_MOD) && a == '0) begin
            r.status = ST_DIV0;
          end else begin
            sa = longint'($signed(a));
            sb = longint'($signed(b));
            case (x.func)
              FN_ADD:  res = b + a;
              FN_SUB:  res = b - a;
              FN_MUL:  res = b * a;
              FN_DIV:  res = DATA_W'(sb / sa);
              default: res = DATA_W'(sb % sa);
            endcase
            shadow_count--;
            shadow_stack[shadow_count-1] = res;
            r.value = res;
          end
        end
      end
      default: ;
    endcase
    r.compare_flag = shadow_eq;
    r.depth        = DEPTH_W'(shadow_count);
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_operand();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return NEG_ONE;
      2:       return MIN_W;
      3:       return MAX_W;
      4:       return 32'd1;
      5, 6:    return DATA_W'($urandom_range(0, 64));
      7:       return ~DATA_W'($urandom_range(0, 63));
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t random_instr();
    in_t         x;
    int unsigned r, push_w;
    push_w = (shadow_count < 4) ? 60 : ((shadow_count > 48) ? 15 : 35);
    x.operand = pick_operand();
    r = $urandom_range(0, 99);
    if (r < push_w) begin
      x.func = FN_PUSH;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        x.func = arith_ops[$urandom_range(0, 4)];
      end else if (r < 65) begin
        x.func = FN_POP;
      end else if (r < 80) begin
        x.func = FN_CMP;
        if (shadow_count > 0 && $urandom_range(0, 1) == 1)
          x.operand = shadow_stack[shadow_count-1];
      end else if (r < 92) begin
        x.func = FN_PEEK;
      end else begin
        x.func = FUNC_W'($urandom_range(FN_PEEK + 1, FN_SPARE));
      end
    end
    return x;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (no_idle || r < 5) return 0;
    if (r < 8) return $urandom_range(1, 3);
    return $urandom_range(5, 16);
  endfunction

  task automatic issue(input in_t x, input logic known, input out_t result);
    int unsigned gap;
    out_t        predicted;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= x;
    do @(posedge clk_i); while (in_stall_o);
    predicted = execute_instr(x);
    pending_results.push_back(known ? result : predicted);
  endtask

  // receiver back-pressure
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (!no_idle && $urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(4, 15);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected item: expected none, got value %0d status %0d depth %0d",
                 $time, out_data_o.value, out_data_o.status, out_data_o.depth);
      end else begin
        want_result = pending_results.pop_front();
        check_field("value", want_result.value, out_data_o.value);
        check_field("status", want_result.status, out_data_o.status);
        check_field("compare_flag", want_result.compare_flag, out_data_o.compare_flag);
        check_field("depth", want_result.depth, out_data_o.depth);
      end
    end
  end

  initial begin
    in_t x;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_steps[i])
      issue(directed_steps[i].stim, directed_steps[i].known, directed_steps[i].result);

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 25 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_ITEMS / 2) begin
        // fill to the top and push into a full stack
        while (shadow_count < STACK_DEPTH) begin
          x.func    = FN_PUSH;
          x.operand = pick_operand();
          issue(x, 1'b0, '0);
        end
        repeat (3) begin
          x.func    = FN_PUSH;
          x.operand = pick_operand();
          issue(x, 1'b0, '0);
        end
        x.func    = FN_PEEK;
        issue(x, 1'b0, '0);
      end
      issue(random_instr(), 1'b0, '0);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule
